>>> sv/entropy_rct_apt_health_monitor_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef ENTROPY_RCT_APT_HEALTH_MONITOR_ASSERT_SVH
`define ENTROPY_RCT_APT_HEALTH_MONITOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ERAHM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("health monitor assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ERAHM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("health monitor assertion failed");

`endif

>>> sv/erahm_pkg.sv
package erahm_pkg;

  localparam int unsigned SAMPLE_W    = 8;
  localparam int unsigned CNT8_W      = 8;
  localparam int unsigned CNT11_W     = 11;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 11;

  localparam logic [CNT8_W-1:0]  CNT8_MAX  = '1;
  localparam logic [CNT11_W-1:0] CNT11_MAX = '1;

  localparam logic [CNT8_W-1:0]  REPEAT_LIMIT_RST      = 8'd5;
  localparam logic [CNT11_W-1:0] WINDOW_LENGTH_RST     = 11'd64;
  localparam logic [CNT11_W-1:0] MATCH_CUTOFF_RST      = 11'd5;
  localparam logic [CNT8_W-1:0]  FAILURE_THRESHOLD_RST = 8'd0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_REPEAT_LIMIT      = 2'd0,
    CFG_WINDOW_LENGTH     = 2'd1,
    CFG_MATCH_CUTOFF      = 2'd2,
    CFG_FAILURE_THRESHOLD = 2'd3
  } cfg_index_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_HEALTHY = 2'd0,
    STATUS_REPEAT  = 2'd1,
    STATUS_WINDOW  = 2'd2
  } status_t;

  typedef enum logic {
    FUNC_TEST    = 1'b0,
    FUNC_RESTART = 1'b1
  } func_t;

  typedef struct packed {
    logic                fire;
    logic                restart;
    logic [SAMPLE_W-1:0] sample;
  } step_t;

  typedef struct packed {
    logic              error;
    logic [CNT8_W-1:0] peak;
  } test_result_t;

  function automatic logic [CNT8_W-1:0] sat_inc8(input logic [CNT8_W-1:0] v);
    return (v == CNT8_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [CNT11_W-1:0] sat_inc11(input logic [CNT11_W-1:0] v);
    return (v == CNT11_MAX) ? v : v + 1'b1;
  endfunction

endpackage

>>> sv/entropy_rct_apt_health_monitor.sv
// Repetition count and adaptive proportion health tests on a byte stream.
// Input channel (in_valid/in_ready) carries func and sample: func low tests
// one sample byte, func high restarts the per-block failure counters.
// Every input transaction produces exactly one output transaction
// (out_valid/out_ready) holding the status, the sticky error flag and the
// peak failure counts per block, all taken after that item's update.
// From input transaction to result there is one input register, then the
// test update and the result register. The tests are compares and
// saturating counters, so a new item is taken every cycle (throughput one
// item per clock) while the receiver keeps taking results.
// When the receiver stalls, the result register holds its transaction, the
// input register fills and in_ready drops until the result is taken.
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always
// taken and must only be made while the block is idle.
// A synchronous reset empties both registers, clears all test state and the
// sticky errors, and loads the default configuration.
module entropy_rct_apt_health_monitor import erahm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   func,
  input  logic [SAMPLE_W-1:0]    sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [STATUS_W-1:0]    health_status,
  output logic                   error_flag,
  output logic [CNT8_W-1:0]      peak_repeat_failures,
  output logic [CNT8_W-1:0]      peak_window_failures,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [CNT8_W-1:0]  repeat_limit;
  logic [CNT11_W-1:0] window_length;
  logic [CNT11_W-1:0] match_cutoff;
  logic [CNT8_W-1:0]  failure_threshold;

  logic                s1_valid;
  logic                s1_func;
  logic [SAMPLE_W-1:0] s1_sample;

  logic         advance;
  step_t        step;
  test_result_t rct_result;
  test_result_t apt_result;
  status_t      status_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_limit      <= REPEAT_LIMIT_RST;
      window_length     <= WINDOW_LENGTH_RST;
      match_cutoff      <= MATCH_CUTOFF_RST;
      failure_threshold <= FAILURE_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_REPEAT_LIMIT:      repeat_limit      <= cfg_data[CNT8_W-1:0];
        CFG_WINDOW_LENGTH:     window_length     <= cfg_data[CNT11_W-1:0];
        CFG_MATCH_CUTOFF:      match_cutoff      <= cfg_data[CNT11_W-1:0];
        CFG_FAILURE_THRESHOLD: failure_threshold <= cfg_data[CNT8_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_func   <= func;
      s1_sample <= sample;
    end
  end

  assign step.fire    = s1_valid && advance;
  assign step.restart = (func_t'(s1_func) == FUNC_RESTART);
  assign step.sample  = s1_sample;

  erahm_rct u_rct (
    .clk               (clk),
    .rst               (rst),
    .step              (step),
    .repeat_limit      (repeat_limit),
    .failure_threshold (failure_threshold),
    .result_next       (rct_result)
  );

  erahm_apt u_apt (
    .clk               (clk),
    .rst               (rst),
    .step              (step),
    .window_length     (window_length),
    .match_cutoff      (match_cutoff),
    .failure_threshold (failure_threshold),
    .result_next       (apt_result)
  );

  always_comb begin
    if (rct_result.error) begin
      status_next = STATUS_REPEAT;
    end else if (apt_result.error) begin
      status_next = STATUS_WINDOW;
    end else begin
      status_next = STATUS_HEALTHY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step.fire) begin
      health_status        <= status_next;
      error_flag           <= rct_result.error || apt_result.error;
      peak_repeat_failures <= rct_result.peak;
      peak_window_failures <= apt_result.peak;
    end
  end

endmodule

>>> sv/erahm_rct.sv
module erahm_rct import erahm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  step_t              step,
  input  logic [CNT8_W-1:0]  repeat_limit,
  input  logic [CNT8_W-1:0]  failure_threshold,
  output test_result_t       result_next
);

  logic                started, started_next;
  logic [SAMPLE_W-1:0] prev_sample, prev_sample_next;
  logic [CNT8_W-1:0]   run_length, run_length_next;
  logic [CNT8_W-1:0]   failures, failures_next;
  logic                error, error_next;
  logic [CNT8_W-1:0]   peak, peak_next;

  logic [CNT8_W-1:0] run_inc;
  logic [CNT8_W-1:0] fail_inc;

  assign run_inc  = sat_inc8(run_length);
  assign fail_inc = sat_inc8(failures);

  always_comb begin
    started_next     = started;
    prev_sample_next = prev_sample;
    run_length_next  = run_length;
    failures_next    = failures;
    error_next       = error;
    peak_next        = peak;
    if (step.fire) begin
      if (step.restart) begin
        started_next    = 1'b0;
        run_length_next = 8'd1;
        failures_next   = '0;
      end else if (!started) begin
        started_next     = 1'b1;
        prev_sample_next = step.sample;
      end else if (prev_sample != step.sample) begin
        prev_sample_next = step.sample;
        run_length_next  = 8'd1;
      end else if (run_inc >= repeat_limit) begin
        run_length_next = 8'd1;
        failures_next   = fail_inc;
        if (fail_inc > failure_threshold) begin
          error_next = 1'b1;
        end
        if (fail_inc > peak) begin
          peak_next = fail_inc;
        end
      end else begin
        run_length_next = run_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started     <= 1'b0;
      prev_sample <= '0;
      run_length  <= 8'd1;
      failures    <= '0;
      error       <= 1'b0;
      peak        <= '0;
    end else begin
      started     <= started_next;
      prev_sample <= prev_sample_next;
      run_length  <= run_length_next;
      failures    <= failures_next;
      error       <= error_next;
      peak        <= peak_next;
    end
  end

  assign result_next.error = error_next;
  assign result_next.peak  = peak_next;

endmodule

>>> sv/erahm_apt.sv
module erahm_apt import erahm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  step_t              step,
  input  logic [CNT11_W-1:0] window_length,
  input  logic [CNT11_W-1:0] match_cutoff,
  input  logic [CNT8_W-1:0]  failure_threshold,
  output test_result_t       result_next
);

  logic                started, started_next;
  logic [SAMPLE_W-1:0] ref_sample, ref_sample_next;
  logic [CNT11_W-1:0]  match_count, match_count_next;
  logic [CNT11_W-1:0]  window_count, window_count_next;
  logic [CNT8_W-1:0]   failures, failures_next;
  logic                error, error_next;
  logic [CNT8_W-1:0]   peak, peak_next;

  logic [CNT11_W-1:0] window_inc;
  logic [CNT8_W-1:0]  fail_inc;

  assign window_inc = sat_inc11(window_count);
  assign fail_inc   = sat_inc8(failures);

  always_comb begin
    started_next      = started;
    ref_sample_next   = ref_sample;
    match_count_next  = match_count;
    window_count_next = window_count;
    failures_next     = failures;
    error_next        = error;
    peak_next         = peak;
    if (step.fire) begin
      if (step.restart) begin
        started_next  = 1'b0;
        failures_next = '0;
      end else if (!started) begin
        started_next      = 1'b1;
        ref_sample_next   = step.sample;
        match_count_next  = '0;
        window_count_next = '0;
      end else begin
        window_count_next = window_inc;
        if (window_inc >= window_length) begin
          started_next = 1'b0;
          if (match_count > match_cutoff) begin
            failures_next = fail_inc;
            if (fail_inc > failure_threshold) begin
              error_next = 1'b1;
            end
            if (fail_inc > peak) begin
              peak_next = fail_inc;
            end
          end
        end else if (ref_sample == step.sample) begin
          match_count_next = sat_inc11(match_count);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started      <= 1'b0;
      ref_sample   <= '0;
      match_count  <= '0;
      window_count <= '0;
      failures     <= '0;
      error        <= 1'b0;
      peak         <= '0;
    end else begin
      started      <= started_next;
      ref_sample   <= ref_sample_next;
      match_count  <= match_count_next;
      window_count <= window_count_next;
      failures     <= failures_next;
      error        <= error_next;
      peak         <= peak_next;
    end
  end

  assign result_next.error = error_next;
  assign result_next.peak  = peak_next;

endmodule

>>> sv/erahm_checker.sv
`include "entropy_rct_apt_health_monitor_assert.svh"

module erahm_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] health_status,
  input logic       error_flag,
  input logic [7:0] peak_repeat_failures,
  input logic [7:0] peak_window_failures
);

  // A stalled result must keep its contents.
  `ERAHM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable({health_status, error_flag, peak_repeat_failures, peak_window_failures}))

  // The error flag is set exactly when the status reports an error.
  `ERAHM_ASSERT_IMPLY(a_flag_matches_status, clk, rst, out_valid, error_flag == (health_status != 2'd0) && health_status != 2'd3)

  // Sticky errors do not clear between back-to-back results.
  `ERAHM_ASSERT_IMPLY(a_error_sticky, clk, rst, (out_valid && out_ready) ##1 out_valid, !$past(error_flag) || error_flag)

  // Peak counts never fall between back-to-back results.
  `ERAHM_ASSERT_IMPLY(a_peaks_rise, clk, rst, (out_valid && out_ready) ##1 out_valid, peak_repeat_failures >= $past(peak_repeat_failures) && peak_window_failures >= $past(peak_window_failures))

endmodule

bind entropy_rct_apt_health_monitor erahm_checker u_erahm_checker (.*);

>>> sim/tb.sv
module tb;
  import erahm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t           status;
    logic              flag;
    logic [CNT8_W-1:0] repeat_peak;
    logic [CNT8_W-1:0] window_peak;
  } health_report_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   func = 1'b0;
  logic [SAMPLE_W-1:0]    sample = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [STATUS_W-1:0]    health_status;
  logic                   error_flag;
  logic [CNT8_W-1:0]      peak_repeat_failures;
  logic [CNT8_W-1:0]      peak_window_failures;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  entropy_rct_apt_health_monitor dut (.*);

  // Copy of the configuration as the monitor should hold it.
  logic [CNT8_W-1:0]  lim_q    = REPEAT_LIMIT_RST;
  logic [CNT11_W-1:0] win_len_q = WINDOW_LENGTH_RST;
  logic [CNT11_W-1:0] cutoff_q = MATCH_CUTOFF_RST;
  logic [CNT8_W-1:0]  thresh_q = FAILURE_THRESHOLD_RST;

  // Predicted test state.
  bit                  rct_started = 1'b0;
  logic [SAMPLE_W-1:0] last_byte = '0;
  logic [CNT8_W-1:0]   run_len = 8'd1;
  logic [CNT8_W-1:0]   rct_fails = '0;
  bit                  apt_started = 1'b0;
  logic [SAMPLE_W-1:0] ref_byte = '0;
  logic [CNT11_W-1:0]  match_cnt = '0;
  logic [CNT11_W-1:0]  win_pos = '0;
  logic [CNT8_W-1:0]   apt_fails = '0;
  bit                  rct_err = 1'b0;
  bit                  apt_err = 1'b0;
  logic [CNT8_W-1:0]   rct_peak = '0;
  logic [CNT8_W-1:0]   apt_peak = '0;

  health_report_t pending_reports[$];
  int unsigned    err_count = 0;
  bit             idle_on = 1'b1;

  initial forever #10 clk = ~clk;

  initial begin
    #4ms;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [CNT8_W-1:0] bump8(logic [CNT8_W-1:0] v);
    return (v == 8'hff) ? v : v + 8'd1;
  endfunction

  function automatic logic [CNT11_W-1:0] bump11(logic [CNT11_W-1:0] v);
    return (v == 11'h7ff) ? v : v + 11'd1;
  endfunction

  function automatic health_report_t predict_health(func_t f, logic [SAMPLE_W-1:0] s);
    health_report_t r;
    if (f == FUNC_RESTART) begin
      rct_started = 1'b0;
      run_len     = 8'd1;
      rct_fails   = '0;
      apt_started = 1'b0;
      apt_fails   = '0;
    end else begin
      if (!rct_started) begin
        rct_started = 1'b1;
        last_byte   = s;
      end else if (last_byte != s) begin
        last_byte = s;
        run_len   = 8'd1;
      end else begin
        run_len = bump8(run_len);
        if (run_len >= lim_q) begin
          run_len   = 8'd1;
          rct_fails = bump8(rct_fails);
          if (rct_fails > thresh_q) rct_err = 1'b1;
          if (rct_fails > rct_peak) rct_peak = rct_fails;
        end
      end
      if (!apt_started) begin
        apt_started = 1'b1;
        ref_byte    = s;
        match_cnt   = '0;
        win_pos     = '0;
      end else begin
        win_pos = bump11(win_pos);
        if (win_pos >= win_len_q) begin
          apt_started = 1'b0;
          if (match_cnt > cutoff_q) begin
            apt_fails = bump8(apt_fails);
            if (apt_fails > thresh_q) apt_err = 1'b1;
            if (apt_fails > apt_peak) apt_peak = apt_fails;
          end
        end else if (ref_byte == s) begin
          match_cnt = bump11(match_cnt);
        end
      end
    end
    r.status      = rct_err ? STATUS_REPEAT : (apt_err ? STATUS_WINDOW : STATUS_HEALTHY);
    r.flag        = rct_err | apt_err;
    r.repeat_peak = rct_peak;
    r.window_peak = apt_peak;
    return r;
  endfunction

  always @(posedge clk) begin
    out_ready <= idle_on ? ($urandom_range(99) >= 27) : 1'b1;
  end

  always @(posedge clk) begin
    health_report_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $error("result transaction with no expectation waiting");
        err_count++;
      end else begin
        exp_r = pending_reports.pop_front();
        if (health_status !== exp_r.status) begin
          $error("health_status expected %0d actual %0d", exp_r.status, health_status);
          err_count++;
        end
        if (error_flag !== exp_r.flag) begin
          $error("error_flag expected %0d actual %0d", exp_r.flag, error_flag);
          err_count++;
        end
        if (peak_repeat_failures !== exp_r.repeat_peak) begin
          $error("peak_repeat_failures expected %0d actual %0d",
                 exp_r.repeat_peak, peak_repeat_failures);
          err_count++;
        end
        if (peak_window_failures !== exp_r.window_peak) begin
          $error("peak_window_failures expected %0d actual %0d",
                 exp_r.window_peak, peak_window_failures);
          err_count++;
        end
      end
    end
  end

  // The valid stays high after a transaction only if the next call drives a new item
  // in the same step; otherwise the idle loop of send_item or wait_drained lowers it.
  task automatic send_item(func_t f, logic [SAMPLE_W-1:0] s);
    while (idle_on && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    sample   <= s;
    do @(posedge clk); while (!in_ready);
    pending_reports.push_back(predict_health(f, s));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_REPEAT_LIMIT:      lim_q = v[CNT8_W-1:0];
      CFG_WINDOW_LENGTH:     win_len_q = v;
      CFG_MATCH_CUTOFF:      cutoff_q = v;
      CFG_FAILURE_THRESHOLD: thresh_q = v[CNT8_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(logic [CNT8_W-1:0] rl, logic [CNT11_W-1:0] wl,
                              logic [CNT11_W-1:0] mc, logic [CNT8_W-1:0] ft);
    wait_drained();
    write_reg(CFG_REPEAT_LIMIT, {3'b000, rl});
    write_reg(CFG_WINDOW_LENGTH, wl);
    write_reg(CFG_MATCH_CUTOFF, mc);
    write_reg(CFG_FAILURE_THRESHOLD, {3'b000, ft});
    cfg_valid <= 1'b0;
  endtask

  task automatic test_defaults();
    send_item(FUNC_TEST, 8'h00);
    send_item(FUNC_TEST, 8'hff);
    send_item(FUNC_TEST, 8'h00);
    send_item(FUNC_TEST, 8'hff);
  endtask

  // The proportion error must come first, or the repetition error hides it.
  task automatic test_window_error();
    program_regs(8'd255, 11'd4, 11'd0, 8'd0);
    send_item(FUNC_RESTART, 8'h5a);
    send_item(FUNC_TEST, 8'haa);
    send_item(FUNC_TEST, 8'haa);
    send_item(FUNC_TEST, 8'h55);
    send_item(FUNC_TEST, 8'haa);
    send_item(FUNC_TEST, 8'h00);
  endtask

  task automatic test_repeat_error();
    program_regs(8'd3, 11'd4, 11'd0, 8'd1);
    send_item(FUNC_RESTART, 8'hff);
    repeat (6) send_item(FUNC_TEST, 8'hff);
  endtask

  task automatic test_low_limits();
    program_regs(8'd1, 11'd0, 11'd0, 8'd0);
    send_item(FUNC_RESTART, 8'h00);
    send_item(FUNC_TEST, 8'h00);
    send_item(FUNC_TEST, 8'h00);
    send_item(FUNC_TEST, 8'h81);
    program_regs(8'd0, 11'd1, 11'd0, 8'd0);
    send_item(FUNC_TEST, 8'h7f);
    send_item(FUNC_TEST, 8'h7f);
    send_item(FUNC_TEST, 8'h7f);
  endtask

  task automatic run_random_phase(int unsigned count);
    logic [SAMPLE_W-1:0] base;
    logic [SAMPLE_W-1:0] cur;
    int unsigned         alpha;
    int unsigned         k;
    alpha = $urandom_range(3);
    base  = 8'($urandom);
    cur   = base;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(99) < 3) begin
        send_item(FUNC_RESTART, 8'($urandom));
      end else begin
        if ($urandom_range(99) < 35) begin
          case (alpha)
            0: cur = base;
            1: cur = base ^ ($urandom_range(1) ? 8'hff : 8'h00);
            2: cur = base ^ 8'($urandom_range(15));
            default: cur = 8'($urandom);
          endcase
        end
        send_item(FUNC_TEST, ($urandom_range(99) < 5) ? 8'($urandom) : cur);
      end
    end
  endtask

  task automatic test_random_stream();
    logic [CNT8_W-1:0]  rl;
    logic [CNT11_W-1:0] wl;
    logic [CNT11_W-1:0] mc;
    logic [CNT8_W-1:0]  ft;
    int unsigned        p;
    for (p = 0; p < 8; p++) begin
      case ($urandom_range(3))
        0: rl = 8'd0;
        1: rl = 8'd1;
        2: rl = 8'd255;
        default: rl = 8'($urandom_range(2, 8));
      endcase
      case ($urandom_range(5))
        0: wl = 11'd0;
        1: wl = 11'd1;
        2: wl = 11'd1024;
        default: wl = 11'($urandom_range(2, 40));
      endcase
      case ($urandom_range(3))
        0: mc = 11'd0;
        1: mc = 11'd2047;
        default: mc = 11'($urandom_range(0, 12));
      endcase
      case ($urandom_range(3))
        0: ft = 8'd0;
        1: ft = 8'd255;
        default: ft = 8'($urandom_range(0, 5));
      endcase
      program_regs(rl, wl, mc, ft);
      idle_on = (p != 3);
      run_random_phase(80);
      idle_on = 1'b1;
    end
  endtask

  task automatic test_long_window();
    int unsigned k;
    program_regs(8'd255, 11'd512, 11'd500, 8'd0);
    send_item(FUNC_RESTART, 8'h00);
    for (k = 0; k < 520; k++) begin
      send_item(FUNC_TEST, ($urandom_range(99) < 2) ? 8'hc3 : 8'h3c);
    end
  endtask

  // Both failure counters and both peaks run into saturation here.
  task automatic test_saturation();
    int unsigned k;
    program_regs(8'd0, 11'd2, 11'd0, 8'd255);
    send_item(FUNC_RESTART, 8'h00);
    for (k = 0; k < 260; k++) begin
      send_item(FUNC_TEST, 8'hff);
      send_item(FUNC_TEST, 8'hff);
      send_item(FUNC_TEST, 8'h00);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_defaults();
    test_window_error();
    test_repeat_error();
    test_low_limits();
    test_random_stream();
    test_long_window();
    test_saturation();
    wait_drained();
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
